/* rtl/hrpi_pkg.sv */
`default_nettype none
package hrpi_pkg;

  localparam int unsigned HUE_W = 12;
  localparam logic [HUE_W-1:0] HUE_FULL = 12'd3600;
  localparam int unsigned MODE_W = 4;

  localparam int unsigned HNUM_W = 21;
  localparam int unsigned HDEN_W = 9;
  localparam int unsigned HQ_W = 12;
  localparam int unsigned SNUM_W = 24;
  localparam int unsigned SDEN_W = 8;
  localparam int unsigned SQ_W = 16;

  localparam int unsigned DIV_STAGES = 4;
  localparam int unsigned HUE_STEP = HQ_W / DIV_STAGES;
  localparam int unsigned SAT_STEP = SQ_W / DIV_STAGES;

  localparam logic [7:0] GRAY_LEVEL = 8'hc0;
  localparam logic [7:0] FULL_LEVEL = 8'hff;

  typedef enum logic [1:0] {
    CFG_HUE_START = 2'd0,
    CFG_HUE_END   = 2'd1,
    CFG_BG_MODE   = 2'd2
  } cfg_reg_e;

  typedef enum logic [MODE_W-1:0] {
    BG_CLEAR     = 4'd0,
    BG_GRAY      = 4'd1,
    BG_BLACK     = 4'd2,
    BG_WHITE     = 4'd3,
    BG_GRAYSCALE = 4'd4,
    BG_COPY      = 4'd5,
    BG_DESAT     = 4'd6,
    BG_DARKEN    = 4'd7
  } bg_mode_e;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    pix_t        pix;
    logic        gray;
    logic [15:0] l16;
  } prep_t;

  typedef struct packed {
    logic [HNUM_W-1:0] hnum;
    logic [HDEN_W-1:0] hden;
    logic [SNUM_W-1:0] snum;
    logic [SDEN_W-1:0] sden;
  } div_in_t;

  typedef struct packed {
    logic [HUE_W-1:0]  lo;
    logic [HUE_W-1:0]  hi;
    logic [MODE_W-1:0] mode;
  } cfg_t;

endpackage
`default_nettype wire

/* rtl/hrpi_prep.sv */
`default_nettype none
module hrpi_prep
  import hrpi_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  pix_t    pix_i,
  output logic    valid_o,
  input  logic    ready_i,
  output div_in_t div_o,
  output prep_t   side_o
);

  logic [7:0]         mx;
  logic [7:0]         mn;
  logic [7:0]         d;
  logic [8:0]         sum;
  logic               r_max;
  logic               g_max;
  logic [11:0]        base;
  logic signed [9:0]  diff;
  logic [19:0]        base_d;
  logic signed [20:0] diff600;
  logic signed [20:0] n;
  logic [7:0]         den;
  div_in_t            div_d;
  prep_t              side_d;
  div_in_t            div_q;
  prep_t              side_q;
  logic               v_q;
  logic               en;

  always_comb begin
    mx = pix_i.red;
    if (pix_i.green > mx) mx = pix_i.green;
    if (pix_i.blue > mx) mx = pix_i.blue;
    mn = pix_i.red;
    if (pix_i.green < mn) mn = pix_i.green;
    if (pix_i.blue < mn) mn = pix_i.blue;
    d = mx - mn;
    sum = 9'(mx) + 9'(mn);
    r_max = (mx == pix_i.red);
    g_max = !r_max && (mx == pix_i.green);
    if (r_max) begin
      base = (pix_i.green >= pix_i.blue) ? 12'd0 : HUE_FULL;
      diff = $signed({2'b00, pix_i.green}) - $signed({2'b00, pix_i.blue});
    end else if (g_max) begin
      base = 12'd1200;
      diff = $signed({2'b00, pix_i.blue}) - $signed({2'b00, pix_i.red});
    end else begin
      base = 12'd2400;
      diff = $signed({2'b00, pix_i.red}) - $signed({2'b00, pix_i.green});
    end
    base_d = 20'(base) * 20'(d);
    diff600 = $signed({{11{diff[9]}}, diff}) * 21'sd600;
    n = $signed({1'b0, base_d}) + diff600;
    den = (sum <= 9'd255) ? sum[7:0] : 8'(9'd510 - sum);

    div_d.hnum = {n[19:0], 1'b0} + HNUM_W'(d);
    div_d.hden = {d, 1'b0};
    div_d.snum = {d, 16'h0000} - SNUM_W'(d) + SNUM_W'(den[7:1]);
    div_d.sden = den;

    side_d.pix = pix_i;
    side_d.gray = (d == 8'd0);
    side_d.l16 = {sum, 7'b0} + 16'((10'(sum) + 10'd1) >> 1);
  end

  assign en = !v_q || ready_i;
  assign ready_o = en;
  assign valid_o = v_q;
  assign div_o = div_q;
  assign side_o = side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      div_q <= div_d;
      side_q <= side_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/hrpi_div.sv */
`default_nettype none
module hrpi_div
  import hrpi_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  div_in_t         div_i,
  input  prep_t           side_i,
  output logic            valid_o,
  input  logic            ready_i,
  output logic [HQ_W-1:0] hue_o,
  output logic [SQ_W-1:0] sat_o,
  output prep_t           side_o
);

  localparam int unsigned LAST = DIV_STAGES - 1;

  logic              v_q [DIV_STAGES];
  logic              en [DIV_STAGES+1];
  logic [HQ_W-1:0]   hq_q [DIV_STAGES];
  logic [SQ_W-1:0]   sq_q [DIV_STAGES];
  prep_t             side_q [DIV_STAGES];
  logic [HNUM_W-1:0] hrem_q [LAST];
  logic [HDEN_W-1:0] hden_q [LAST];
  logic [SNUM_W-1:0] srem_q [LAST];
  logic [SDEN_W-1:0] sden_q [LAST];

  always_comb begin
    en[DIV_STAGES] = ready_i;
    for (int i = DIV_STAGES - 1; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  for (genvar st = 0; st < DIV_STAGES; st++) begin : g_stage
    logic [HNUM_W-1:0] h_rem_in;
    logic [HNUM_W-1:0] h_rem;
    logic [HDEN_W-1:0] h_den_in;
    logic [HQ_W-1:0]   h_q_in;
    logic [HQ_W-1:0]   h_q;
    logic [SNUM_W-1:0] s_rem_in;
    logic [SNUM_W-1:0] s_rem;
    logic [SDEN_W-1:0] s_den_in;
    logic [SQ_W-1:0]   s_q_in;
    logic [SQ_W-1:0]   s_q;
    prep_t             side_in;
    logic              v_in;

    if (st == 0) begin : g_first
      assign h_rem_in = div_i.hnum;
      assign h_den_in = div_i.hden;
      assign h_q_in = '0;
      assign s_rem_in = div_i.snum;
      assign s_den_in = div_i.sden;
      assign s_q_in = '0;
      assign side_in = side_i;
      assign v_in = valid_i;
    end else begin : g_next
      assign h_rem_in = hrem_q[st-1];
      assign h_den_in = hden_q[st-1];
      assign h_q_in = hq_q[st-1];
      assign s_rem_in = srem_q[st-1];
      assign s_den_in = sden_q[st-1];
      assign s_q_in = sq_q[st-1];
      assign side_in = side_q[st-1];
      assign v_in = v_q[st-1];
    end

    always_comb begin
      h_rem = h_rem_in;
      h_q = h_q_in;
      for (int j = 0; j < HUE_STEP; j++) begin
        if (h_rem >= (HNUM_W'(h_den_in) << (HQ_W - 1 - st * HUE_STEP - j))) begin
          h_rem = h_rem - (HNUM_W'(h_den_in) << (HQ_W - 1 - st * HUE_STEP - j));
          h_q[HQ_W-1-st*HUE_STEP-j] = 1'b1;
        end
      end
      s_rem = s_rem_in;
      s_q = s_q_in;
      for (int j = 0; j < SAT_STEP; j++) begin
        if (s_rem >= (SNUM_W'(s_den_in) << (SQ_W - 1 - st * SAT_STEP - j))) begin
          s_rem = s_rem - (SNUM_W'(s_den_in) << (SQ_W - 1 - st * SAT_STEP - j));
          s_q[SQ_W-1-st*SAT_STEP-j] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[st] <= 1'b0;
      end else if (en[st]) begin
        v_q[st] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[st]) begin
        hq_q[st] <= h_q;
        sq_q[st] <= s_q;
        side_q[st] <= side_in;
      end
    end

    if (st < LAST) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en[st]) begin
          hrem_q[st] <= h_rem;
          hden_q[st] <= h_den_in;
          srem_q[st] <= s_rem;
          sden_q[st] <= s_den_in;
        end
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[LAST];
  assign hue_o = hq_q[LAST];
  assign sat_o = sq_q[LAST];
  assign side_o = side_q[LAST];

endmodule
`default_nettype wire

/* rtl/hrpi_hsl.sv */
`default_nettype none
module hrpi_hsl
  import hrpi_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  logic [HQ_W-1:0] hue_i,
  input  logic [SQ_W-1:0] sat_i,
  input  prep_t           side_i,
  input  cfg_t            cfg_i,
  output logic            valid_o,
  input  logic            ready_i,
  output pix_t            pix_o,
  output logic            match_o
);

  localparam int unsigned NST = 9;
  localparam logic [22:0] M100 = 23'd5368710;
  localparam logic [23:0] M75 = 24'd14316558;

  typedef struct packed {
    pix_t       pix;
    logic       match;
    logic [7:0] gavg;
  } keep_t;

  function automatic logic [7:0] to_byte(input logic [17:0] v);
    logic [25:0] y;
    logic [26:0] t;
    begin
      y = (26'(v) * 26'd255 + 26'd65535) >> 1;
      t = 27'(y) + 27'(y >> 16) + 27'd1;
      to_byte = (t[26:16] > 11'd255) ? FULL_LEVEL : t[23:16];
    end
  endfunction

  logic  v_q [NST];
  logic  en [NST+1];
  keep_t k_q [NST-1];

  logic [HUE_W-1:0] h1_d;
  logic [15:0]      s1_d;
  logic [9:0]       gsum;
  logic [19:0]      gprod;
  keep_t            k1_d;
  logic [21:0]      dn1_d;
  logic [HUE_W-1:0] h1_q;
  logic [15:0]      s1_q;
  logic [15:0]      l1_q;
  logic [21:0]      dn1_q;

  logic [44:0]      dprod;
  logic [2:0]       sec2_d;
  logic [HUE_W-1:0] secbase;
  logic [9:0]       f2;
  logic [9:0]       ff2_d;
  logic [15:0]      ld2_q;
  logic [15:0]      l2_q;
  logic [15:0]      s2_q;
  logic [2:0]       sec2_q;
  logic [9:0]       ff2_q;

  logic [15:0] lsel;
  logic [15:0] ssel;
  logic [14:0] kk;
  logic [32:0] y3_q;
  logic [15:0] l3_q;
  logic [2:0]  sec3_q;
  logic [9:0]  ff3_q;

  logic [32:0] t4;
  logic [15:0] c4_q;
  logic [15:0] l4_q;
  logic [2:0]  sec4_q;
  logic [9:0]  ff4_q;

  logic [25:0] cf5_q;
  logic [16:0] m5_q;
  logic [15:0] c5_q;
  logic [2:0]  sec5_q;

  logic [25:0] xn;
  logic [46:0] xprod;
  logic [15:0] x6_q;
  logic [16:0] m6_q;
  logic [15:0] c6_q;
  logic [2:0]  sec6_q;

  logic [16:0] c2;
  logic [16:0] x2;
  logic [16:0] ar;
  logic [16:0] ag;
  logic [16:0] ab;
  logic [17:0] vr7_q;
  logic [17:0] vg7_q;
  logic [17:0] vb7_q;

  logic [7:0] r8_q;
  logic [7:0] g8_q;
  logic [7:0] b8_q;

  pix_t pix9_d;
  pix_t pix9_q;
  logic m9_q;

  always_comb begin
    en[NST] = ready_i;
    for (int i = NST - 1; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  always_comb begin
    if (side_i.gray) begin
      h1_d = '0;
      s1_d = '0;
    end else begin
      h1_d = (hue_i >= HUE_FULL) ? hue_i - HUE_FULL : hue_i;
      s1_d = sat_i;
    end
    gsum = 10'(side_i.pix.red) + 10'(side_i.pix.green) + 10'(side_i.pix.blue) + 10'd1;
    gprod = 20'(gsum) * 20'd683;
    k1_d.pix = side_i.pix;
    k1_d.match = (h1_d >= cfg_i.lo) && (h1_d <= cfg_i.hi);
    k1_d.gavg = gprod[18:11];
    dn1_d = 22'(side_i.l16) * 22'd35 + 22'd50;
  end

  always_comb begin
    dprod = 45'(dn1_q) * 45'(M100);
    if (h1_q >= 12'd3000) begin
      sec2_d = 3'd5;
      secbase = 12'd3000;
    end else if (h1_q >= 12'd2400) begin
      sec2_d = 3'd4;
      secbase = 12'd2400;
    end else if (h1_q >= 12'd1800) begin
      sec2_d = 3'd3;
      secbase = 12'd1800;
    end else if (h1_q >= 12'd1200) begin
      sec2_d = 3'd2;
      secbase = 12'd1200;
    end else if (h1_q >= 12'd600) begin
      sec2_d = 3'd1;
      secbase = 12'd600;
    end else begin
      sec2_d = 3'd0;
      secbase = 12'd0;
    end
    f2 = 10'(h1_q - secbase);
    ff2_d = sec2_d[0] ? 10'd600 - f2 : f2;
  end

  always_comb begin
    lsel = (cfg_i.mode == BG_DARKEN) ? ld2_q : l2_q;
    ssel = (cfg_i.mode == BG_DESAT) ? 16'd0 : s2_q;
    kk = (lsel <= 16'd32767) ? lsel[14:0] : 15'(16'hffff - lsel);
  end

  assign t4 = y3_q + (y3_q >> 16) + 33'd1;

  always_comb begin
    xn = cf5_q + 26'd300;
    xprod = 47'(xn[25:3]) * 47'(M75);
  end

  always_comb begin
    c2 = {c6_q, 1'b0};
    x2 = {x6_q, 1'b0};
    case (sec6_q)
      3'd0: begin ar = c2; ag = x2; ab = '0; end
      3'd1: begin ar = x2; ag = c2; ab = '0; end
      3'd2: begin ar = '0; ag = c2; ab = x2; end
      3'd3: begin ar = '0; ag = x2; ab = c2; end
      3'd4: begin ar = x2; ag = '0; ab = c2; end
      default: begin ar = c2; ag = '0; ab = x2; end
    endcase
  end

  always_comb begin
    pix9_d = k_q[7].pix;
    if (!k_q[7].match) begin
      case (cfg_i.mode)
        BG_CLEAR: begin
          pix9_d = '0;
        end
        BG_GRAY: begin
          pix9_d.alpha = FULL_LEVEL;
          pix9_d.red = GRAY_LEVEL;
          pix9_d.green = GRAY_LEVEL;
          pix9_d.blue = GRAY_LEVEL;
        end
        BG_BLACK: begin
          pix9_d.alpha = FULL_LEVEL;
          pix9_d.red = '0;
          pix9_d.green = '0;
          pix9_d.blue = '0;
        end
        BG_WHITE: begin
          pix9_d.alpha = FULL_LEVEL;
          pix9_d.red = FULL_LEVEL;
          pix9_d.green = FULL_LEVEL;
          pix9_d.blue = FULL_LEVEL;
        end
        BG_GRAYSCALE: begin
          pix9_d.alpha = FULL_LEVEL;
          pix9_d.red = k_q[7].gavg;
          pix9_d.green = k_q[7].gavg;
          pix9_d.blue = k_q[7].gavg;
        end
        BG_COPY: begin
          pix9_d = k_q[7].pix;
        end
        BG_DESAT, BG_DARKEN: begin
          pix9_d.red = r8_q;
          pix9_d.green = g8_q;
          pix9_d.blue = b8_q;
        end
        default: begin
          pix9_d.alpha = FULL_LEVEL;
          pix9_d.green = '0;
          pix9_d.blue = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NST; i++) begin
        v_q[i] <= 1'b0;
      end
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      h1_q <= h1_d;
      s1_q <= s1_d;
      l1_q <= side_i.l16;
      dn1_q <= dn1_d;
      k_q[0] <= k1_d;
    end
    if (en[1]) begin
      ld2_q <= dprod[44:29];
      l2_q <= l1_q;
      s2_q <= s1_q;
      sec2_q <= sec2_d;
      ff2_q <= ff2_d;
      k_q[1] <= k_q[0];
    end
    if (en[2]) begin
      y3_q <= 33'({kk, 1'b0}) * 33'(ssel) + 33'd32767;
      l3_q <= lsel;
      sec3_q <= sec2_q;
      ff3_q <= ff2_q;
      k_q[2] <= k_q[1];
    end
    if (en[3]) begin
      c4_q <= t4[31:16];
      l4_q <= l3_q;
      sec4_q <= sec3_q;
      ff4_q <= ff3_q;
      k_q[3] <= k_q[2];
    end
    if (en[4]) begin
      cf5_q <= 26'(c4_q) * 26'(ff4_q);
      m5_q <= {l4_q, 1'b0} - 17'(c4_q);
      c5_q <= c4_q;
      sec5_q <= sec4_q;
      k_q[4] <= k_q[3];
    end
    if (en[5]) begin
      x6_q <= xprod[45:30];
      m6_q <= m5_q;
      c6_q <= c5_q;
      sec6_q <= sec5_q;
      k_q[5] <= k_q[4];
    end
    if (en[6]) begin
      vr7_q <= 18'(m6_q) + 18'(ar);
      vg7_q <= 18'(m6_q) + 18'(ag);
      vb7_q <= 18'(m6_q) + 18'(ab);
      k_q[6] <= k_q[5];
    end
    if (en[7]) begin
      r8_q <= to_byte(vr7_q);
      g8_q <= to_byte(vg7_q);
      b8_q <= to_byte(vb7_q);
      k_q[7] <= k_q[6];
    end
    if (en[8]) begin
      pix9_q <= pix9_d;
      m9_q <= k_q[7].match;
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NST-1];
  assign pix_o = pix9_q;
  assign match_o = m9_q;

endmodule
`default_nettype wire

/* rtl/hue_range_pixel_isolation.sv */
// Hue range color key for a stream of ARGB pixels.
// Pixels enter on the in channel (in_valid_i/in_ready_o) and leave on the out
// channel (out_valid_o/out_ready_i), one result item for every input item, in
// order. A pixel whose HSL hue lies inside the configured range passes
// unchanged with hue_matched_o set; any other pixel is replaced as the
// background mode selects.
// The pipeline has fourteen register stages: one for channel extrema and
// divider operands, four for the hue and saturation dividers, and nine for
// HSL reconstruction and the output mux. One item is accepted in every cycle
// while the receiver takes items. The user must write the registers through
// cfg_valid_i/cfg_index_i/cfg_value_i only while no item is in flight; the
// block does not enforce this, and cfg_ready_o is always high.
// Reset empties the pipeline and loads hue start 0, hue end 3600 and the clear
// mode. When the receiver stalls, stages fill up behind the output register;
// in_ready_o falls only once every stage holds an item, and nothing is lost.
`default_nettype none
module hue_range_pixel_isolation
  import hrpi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_value_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  alpha_in_i,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  alpha_out_o,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o,
  output logic        hue_matched_o
);

  logic [HUE_W-1:0]  start_q;
  logic [HUE_W-1:0]  end_q;
  logic [MODE_W-1:0] mode_q;
  logic [HUE_W-1:0]  hi_clamp;
  cfg_t              cfg;

  pix_t            pix_in;
  pix_t            pix_out;
  logic            prep_valid;
  logic            prep_ready;
  div_in_t         div_ops;
  prep_t           prep_side;
  logic            div_valid;
  logic            div_ready;
  logic [HQ_W-1:0] hue_q;
  logic [SQ_W-1:0] sat_q;
  prep_t           div_side;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      end_q <= HUE_FULL;
      mode_q <= BG_CLEAR;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_HUE_START: start_q <= cfg_value_i;
        CFG_HUE_END: end_q <= cfg_value_i;
        CFG_BG_MODE: mode_q <= cfg_value_i[MODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    hi_clamp = (end_q > HUE_FULL) ? HUE_FULL : end_q;
    cfg.mode = mode_q;
    if (start_q > hi_clamp) begin
      cfg.lo = hi_clamp;
      cfg.hi = start_q;
    end else begin
      cfg.lo = start_q;
      cfg.hi = hi_clamp;
    end
  end

  assign pix_in.alpha = alpha_in_i;
  assign pix_in.red = red_in_i;
  assign pix_in.green = green_in_i;
  assign pix_in.blue = blue_in_i;

  hrpi_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .pix_i   (pix_in),
    .valid_o (prep_valid),
    .ready_i (prep_ready),
    .div_o   (div_ops),
    .side_o  (prep_side)
  );

  hrpi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid),
    .ready_o (prep_ready),
    .div_i   (div_ops),
    .side_i  (prep_side),
    .valid_o (div_valid),
    .ready_i (div_ready),
    .hue_o   (hue_q),
    .sat_o   (sat_q),
    .side_o  (div_side)
  );

  hrpi_hsl u_hsl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_valid),
    .ready_o (div_ready),
    .hue_i   (hue_q),
    .sat_i   (sat_q),
    .side_i  (div_side),
    .cfg_i   (cfg),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .pix_o   (pix_out),
    .match_o (hue_matched_o)
  );

  assign alpha_out_o = pix_out.alpha;
  assign red_out_o = pix_out.red;
  assign green_out_o = pix_out.green;
  assign blue_out_o = pix_out.blue;

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("Input stalled while the output stage is empty.");

  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("Input stalled while the receiver takes items.");

  a_reset_empty: assert property (@(posedge clk_i)
    rst_ni && $past(!rst_ni) |-> !out_valid_o)
    else $error("Result item presented right after reset.");
`endif

endmodule
`default_nettype wire
